// ----- design/apjq_pkg.sv -----
// Package for the array priority job queue.
// Holds the item types, status codes, controller state and the command/status
// structs shared by the controller, datapath and top level.
package apjq_pkg;

    // Default number of queue entries
    localparam int QUEUE_DEPTH_DEF = 8;

    // Operation codes
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    // Result status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_OVERFLOW  = 2'd1;
    localparam logic [1:0] ST_UNDERFLOW = 2'd2;

    // Input item
    typedef struct packed {
        logic        op;
        logic [15:0] job_id;
        logic [7:0]  priority_req;
        logic [15:0] burst_time;
    } job_in_t;

    // Result item
    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] served_id;
        logic [7:0]  served_priority;
        logic [15:0] served_burst;
        logic [3:0]  occupancy;
    } job_out_t;

    // One stored job
    typedef struct packed {
        logic [15:0] id;
        logic [7:0]  prio;
        logic [15:0] burst;
    } job_entry_t;

    localparam int ENTRY_W = $bits(job_entry_t);

    // Controller states
    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT,
        S_DONE
    } state_t;

    // Controller to datapath commands
    typedef struct packed {
        logic accept;
        logic scan_step;
        logic shift_step;
        logic load_out;
    } dp_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic in_remove;
        logic full;
        logic empty;
        logic scan_last;
        logic no_shift;
        logic shift_last;
    } dp_stat_t;

endpackage

// ----- design/apjq_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// Used as the job store of the priority queue; no package dependency.
module apjq_ram #(
    parameter int WIDTH = 40,
    parameter int DEPTH = 8
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- design/apjq_dp.sv -----
// Datapath of the priority job queue: job count, scan and shift indexes,
// best-entry tracking, job store RAM and the result register.
// Depends on apjq_pkg and apjq_ram.
module apjq_dp #(
    parameter int QUEUE_DEPTH = apjq_pkg::QUEUE_DEPTH_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  apjq_pkg::job_in_t  s_data,
    input  apjq_pkg::dp_cmd_t  cmd,
    output apjq_pkg::dp_stat_t stat,
    output apjq_pkg::job_out_t m_data
);

    import apjq_pkg::*;

    localparam int IDX_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int EXT_W = IDX_W + 1;

    logic [CNT_W-1:0] count_reg,    count_next;
    logic [IDX_W-1:0] scan_idx_reg, scan_idx_next;
    logic [IDX_W-1:0] best_idx_reg, best_idx_next;
    logic [IDX_W-1:0] wr_idx_reg,   wr_idx_next;
    job_entry_t       best_reg,     best_next;
    job_entry_t       served_reg,   served_next;
    logic [1:0]       status_reg,   status_next;
    job_out_t         out_reg,      out_next;

    logic             ram_we;
    logic [IDX_W-1:0] ram_waddr;
    job_entry_t       ram_wdata;
    logic [IDX_W-1:0] ram_raddr;
    job_entry_t       ram_rdata;
    logic [ENTRY_W-1:0] ram_rdata_raw;

    job_entry_t       cand_entry;
    logic [IDX_W-1:0] cand_idx;
    logic [EXT_W-1:0] count_ext;
    logic [EXT_W-1:0] scan_inc;
    logic [EXT_W-1:0] cand_inc;
    logic [EXT_W-1:0] wr_inc;
    logic [EXT_W-1:0] wr_inc2;
    logic             insert_ok;

    assign ram_rdata = job_entry_t'(ram_rdata_raw);

    // Index arithmetic one bit wider than the address
    assign count_ext = EXT_W'(count_reg);
    assign scan_inc  = {1'b0, scan_idx_reg} + EXT_W'(1);
    assign cand_inc  = {1'b0, cand_idx} + EXT_W'(1);
    assign wr_inc    = {1'b0, wr_idx_reg} + EXT_W'(1);
    assign wr_inc2   = {1'b0, wr_idx_reg} + EXT_W'(2);

    // Keep the first entry with the strictly largest priority
    always_comb begin
        if (scan_idx_reg == '0 || ram_rdata.prio > best_reg.prio) begin
            cand_entry = ram_rdata;
            cand_idx   = scan_idx_reg;
        end else begin
            cand_entry = best_reg;
            cand_idx   = best_idx_reg;
        end
    end

    // Status toward the controller
    assign stat.in_remove  = (s_data.op == OP_REMOVE);
    assign stat.full       = (count_ext >= EXT_W'(QUEUE_DEPTH));
    assign stat.empty      = (count_reg == '0);
    assign stat.scan_last  = (scan_inc == count_ext);
    assign stat.no_shift   = (cand_inc == count_ext);
    assign stat.shift_last = (wr_inc == count_ext);

    assign insert_ok = cmd.accept && (s_data.op == OP_INSERT) && !stat.full;

    // Store write: append on insert, move one entry down on shift
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = count_reg[IDX_W-1:0];
        ram_wdata.id    = s_data.job_id;
        ram_wdata.prio  = s_data.priority_req;
        ram_wdata.burst = s_data.burst_time;
        if (insert_ok) begin
            ram_we = 1'b1;
        end else if (cmd.shift_step) begin
            ram_we    = 1'b1;
            ram_waddr = wr_idx_reg;
            ram_wdata = ram_rdata;
        end
    end

    // Store read address: next scan entry, or the entry after the write slot
    always_comb begin
        ram_raddr = '0;
        if (cmd.scan_step) begin
            ram_raddr = stat.scan_last ? cand_inc[IDX_W-1:0] : scan_inc[IDX_W-1:0];
        end else if (cmd.shift_step) begin
            ram_raddr = wr_inc2[IDX_W-1:0];
        end
    end

    // Next-state logic for the datapath registers
    always_comb begin
        count_next    = count_reg;
        scan_idx_next = scan_idx_reg;
        best_idx_next = best_idx_reg;
        wr_idx_next   = wr_idx_reg;
        best_next     = best_reg;
        served_next   = served_reg;
        status_next   = status_reg;
        out_next      = out_reg;

        if (cmd.accept) begin
            scan_idx_next = '0;
            served_next   = '0;
            if (s_data.op == OP_INSERT) begin
                status_next = stat.full ? ST_OVERFLOW : ST_OK;
                if (!stat.full) begin
                    count_next = count_reg + CNT_W'(1);
                end
            end else begin
                status_next = stat.empty ? ST_UNDERFLOW : ST_OK;
            end
        end

        if (cmd.scan_step) begin
            scan_idx_next = scan_inc[IDX_W-1:0];
            best_next     = cand_entry;
            best_idx_next = cand_idx;
            if (stat.scan_last) begin
                served_next = cand_entry;
                wr_idx_next = cand_idx;
                count_next  = count_reg - CNT_W'(1);
            end
        end

        if (cmd.shift_step) begin
            wr_idx_next = wr_inc[IDX_W-1:0];
        end

        if (cmd.load_out) begin
            out_next.status          = status_reg;
            out_next.served_id       = served_reg.id;
            out_next.served_priority = served_reg.prio;
            out_next.served_burst    = served_reg.burst;
            out_next.occupancy       = 4'(count_reg);
        end
    end

    // Control state: job count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        scan_idx_reg <= scan_idx_next;
        best_idx_reg <= best_idx_next;
        wr_idx_reg   <= wr_idx_next;
        best_reg     <= best_next;
        served_reg   <= served_next;
        status_reg   <= status_next;
        out_reg      <= out_next;
    end

    assign m_data = out_reg;

    apjq_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata_raw)
    );

    // Count never exceeds the queue depth
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_ext <= EXT_W'(QUEUE_DEPTH))
        else $error("job count above queue depth");

    // A scan only runs over a non-empty queue
    a_scan_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.scan_step |-> count_reg != '0)
        else $error("scan step with empty queue");

    // An overflowing insert leaves the count unchanged
    a_overflow_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.accept && s_data.op == OP_INSERT && stat.full) |=> $stable(count_reg))
        else $error("count changed on overflow");

endmodule

// ----- design/apjq_ctrl.sv -----
// Controller state machine of the priority job queue: accepts items, steps
// the scan and shift, and hands results to the output register.
// Depends on apjq_pkg.
module apjq_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    output logic               m_valid,
    input  logic               m_ready,
    input  apjq_pkg::dp_stat_t stat,
    output apjq_pkg::dp_cmd_t  cmd
);

    import apjq_pkg::*;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;

    // Next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.accept = 1'b1;
                    if (stat.in_remove && !stat.empty) begin
                        state_next = S_SCAN;
                    end else begin
                        state_next = S_DONE;
                    end
                end
            end
            S_SCAN: begin
                cmd.scan_step = 1'b1;
                if (stat.scan_last) begin
                    state_next = stat.no_shift ? S_DONE : S_SHIFT;
                end
            end
            S_SHIFT: begin
                cmd.shift_step = 1'b1;
                if (stat.shift_last) begin
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold the result valid until taken
    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.load_out) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;

    // Loading a result returns to idle with the result valid
    a_load_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |=> (state_reg == S_IDLE && m_valid_reg))
        else $error("result load did not return to idle");

    // A failed or insert item goes straight to result delivery
    a_short_path: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.accept && !(stat.in_remove && !stat.empty)) |=> state_reg == S_DONE)
        else $error("short item did not go to result delivery");

    // Never load a result over one that is still waiting
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.load_out && m_valid_reg) |-> m_ready)
        else $error("result overwritten before taken");

endmodule

// ----- design/array_priority_job_queue.sv -----
// Top level of the array priority job queue.
// Joins apjq_ctrl and apjq_dp; depends on apjq_pkg.
//
// Bounded priority queue of jobs held in a single-port-read RAM of QUEUE_DEPTH
// entries. An insert appends at the tail (status overflow when full) and goes
// from acceptance straight to result delivery. A remove scans the held entries
// one per cycle for the first job of highest priority, then moves each later
// entry down one place, one per cycle, and reports the served job (status
// underflow when empty). One item is worked at a time; a finished result waits
// in an output register while the next item is accepted. Every result carries
// the occupancy after the operation (low 4 bits of the count). No clearing pass
// is needed after reset.
module array_priority_job_queue #(
    parameter int QUEUE_DEPTH = apjq_pkg::QUEUE_DEPTH_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  apjq_pkg::job_in_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output apjq_pkg::job_out_t m_data
);

    import apjq_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    apjq_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    apjq_dp #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .cmd     (cmd),
        .stat    (stat),
        .m_data  (m_data)
    );

endmodule
